>>> src/text_console_cursor_scroll_assert.svh
// Assertion macros shared by the console engine modules.
// Each macro expects clk_i and rst_ni to be visible in the enclosing module.
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TCCS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tccs: assertion failed");

// Next-cycle implication, disabled during reset.
`define TCCS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tccs: assertion failed");

`endif

>>> src/tccs_pkg.sv
// Shared types and constants of the text console engine.
// No dependencies; imported by every module of the block except tccs_ram.
package tccs_pkg;

  localparam int COLUMNS_DEF  = 80;
  localparam int ROWS_DEF     = 25;
  localparam int COLUMNS_MAX  = 256;
  localparam int ROWS_MAX     = 64;
  localparam int CELL_AW_MAX  = $clog2(COLUMNS_MAX * ROWS_MAX);
  localparam int FIELD_AW     = 11;
  localparam int CELL_W       = 16;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;
  localparam logic [CELL_W-1:0] PLAIN_ATTR = 16'h0700;

  localparam logic [7:0] CHAR_CR = 8'd13;
  localparam logic [7:0] CHAR_LF = 8'd10;
  localparam logic [7:0] CHAR_BS = 8'd8;

  typedef enum logic [1:0] {
    OP_PUT  = 2'd0,
    OP_SET  = 2'd1,
    OP_READ = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  // One classified item on its way from the front to the back.
  typedef struct packed {
    cmd_e                   kind;
    logic [CELL_AW_MAX-1:0] addr;    // logical cell index
    logic [CELL_W-1:0]      data;    // cell value for a write
    logic                   scroll;  // scroll up one row after the access
    logic [FIELD_AW-1:0]    cursor;  // cursor reported with the result
  } cmd_t;

endpackage

>>> src/tccs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tccs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/tccs_fifo.sv
// Short command queue between the front and the back of the console engine.
// Depends on tccs_pkg for the command type.
module tccs_fifo import tccs_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t pop_cmd_o,
  output logic empty_o
);

  localparam int PW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW = $clog2(DEPTH + 1);

  cmd_t           entry_q [DEPTH];
  logic [PW-1:0]  wptr_q, rptr_q;
  logic [CNW-1:0] count_q;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= ptr_inc(wptr_q);
      end
      if (pop_i) begin
        rptr_q <= ptr_inc(rptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  assign pop_cmd_o = entry_q[rptr_q];
  assign full_o    = (count_q == CNW'(DEPTH));
  assign empty_o   = (count_q == '0);

endmodule

>>> src/tccs_front.sv
// Front of the console engine: accepts items, tracks cursor and column,
// and turns each item into one cell command. Depends on tccs_pkg.
`include "text_console_cursor_scroll_assert.svh"

module tccs_front import tccs_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          operation_i,
  input  logic [7:0]          char_code_i,
  input  logic [FIELD_AW-1:0] new_cursor_i,
  input  logic [FIELD_AW-1:0] read_address_i,
  input  logic                clear_busy_i,
  input  logic                queue_full_i,
  output logic                push_o,
  output cmd_t                push_cmd_o
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int CW    = $clog2(CELLS);
  localparam int CLW   = $clog2(COLUMNS);
  localparam int QW    = $clog2(ROWS);
  localparam int KSH   = CW + CLW;
  localparam int MW    = CW + 2;
  localparam int PRW   = CW + MW;
  localparam longint RECIP_L =
    ((longint'(1) << KSH) + longint'(COLUMNS) - 1) / longint'(COLUMNS);
  localparam logic [MW-1:0] RECIP   = MW'(RECIP_L);
  localparam logic [CW:0]   CELLS_X = (CW+1)'(CELLS);
  localparam logic [CW:0]   COLS_X  = (CW+1)'(COLUMNS);

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_COL
  } fstate_e;

  fstate_e        state_q;
  logic [CW-1:0]  cursor_q;
  logic [CLW-1:0] col_q;
  logic [CW-1:0]  rem_q;
  logic [QW-1:0]  row_q;

  logic [CW:0]    cur_x, col_x, nxt_cur_x;
  logic [CLW-1:0] nxt_col, col_inc, col_dec;
  logic [CW-1:0]  clamped, wr_addr;
  logic           start_div;
  logic [31:0]    cur_w;
  logic [PRW-1:0] prod;
  logic [QW-1:0]  quo;
  logic [CW-1:0]  row_base, col_rem;

  assign in_ready_o = (state_q == F_IDLE) && !queue_full_i && !clear_busy_i;
  assign push_o     = in_valid_i && in_ready_o;

  assign col_inc = (col_q == CLW'(COLUMNS - 1)) ? '0 : col_q + 1'b1;
  assign col_dec = (col_q == '0) ? CLW'(COLUMNS - 1) : col_q - 1'b1;
  assign clamped = ({21'd0, new_cursor_i} < 32'(CELLS)) ? CW'(new_cursor_i) : CW'(CELLS - 1);

  // Column of a new cursor: row by reciprocal multiply, then subtract whole rows.
  assign prod     = PRW'(rem_q) * PRW'(RECIP);
  assign quo      = prod[KSH +: QW];
  assign row_base = CW'(row_q) * CW'(COLUMNS);
  assign col_rem  = rem_q - row_base;

  always_comb begin
    cur_x     = {1'b0, cursor_q};
    col_x     = (CW+1)'(col_q);
    nxt_cur_x = cur_x;
    nxt_col   = col_q;
    wr_addr   = cursor_q;
    start_div = 1'b0;
    push_cmd_o.kind   = CMD_NONE;
    push_cmd_o.data   = BLANK_CELL;
    push_cmd_o.scroll = 1'b0;
    push_cmd_o.addr   = '0;
    case (op_e'(operation_i))
      OP_PUT: begin
        if (char_code_i == CHAR_CR) begin
          nxt_cur_x = cur_x - col_x;
          nxt_col   = '0;
        end else if (char_code_i == CHAR_LF) begin
          nxt_cur_x = cur_x + COLS_X - col_x;
          nxt_col   = '0;
        end else if (char_code_i == CHAR_BS) begin
          if (cursor_q != '0) begin
            nxt_cur_x       = cur_x - 1'b1;
            nxt_col         = col_dec;
            wr_addr         = cursor_q - 1'b1;
            push_cmd_o.kind = CMD_WRITE;
          end
        end else begin
          nxt_cur_x       = cur_x + 1'b1;
          nxt_col         = col_inc;
          push_cmd_o.kind = CMD_WRITE;
          push_cmd_o.data = PLAIN_ATTR | {8'h00, char_code_i};
        end
        // Past the last cell: scroll and park at the last row's start.
        if (nxt_cur_x >= CELLS_X) begin
          push_cmd_o.scroll = 1'b1;
          nxt_cur_x         = (CW+1)'(CELLS - COLUMNS);
          nxt_col           = '0;
        end
        push_cmd_o.addr = CELL_AW_MAX'(wr_addr);
      end
      OP_SET: begin
        nxt_cur_x = {1'b0, clamped};
        start_div = 1'b1;
      end
      OP_READ: begin
        if ({21'd0, read_address_i} < 32'(CELLS)) begin
          push_cmd_o.kind = CMD_READ;
          push_cmd_o.addr = CELL_AW_MAX'(read_address_i);
        end
      end
      default: begin
      end
    endcase
    cur_w             = 32'(nxt_cur_x);
    push_cmd_o.cursor = cur_w[FIELD_AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= F_IDLE;
      cursor_q <= '0;
      col_q    <= '0;
      rem_q    <= '0;
      row_q    <= '0;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (push_o) begin
            cursor_q <= nxt_cur_x[CW-1:0];
            col_q    <= nxt_col;
            if (start_div) begin
              rem_q   <= clamped;
              state_q <= F_DIV;
            end
          end
        end
        F_DIV: begin
          row_q   <= quo;
          state_q <= F_COL;
        end
        F_COL: begin
          col_q   <= col_rem[CLW-1:0];
          state_q <= F_IDLE;
        end
        default: begin
          state_q <= F_IDLE;
        end
      endcase
    end
  end

  `TCCS_ASSERT_IMP(a_cursor_on_screen, 1'b1, {1'b0, cursor_q} < CELLS_X)
  `TCCS_ASSERT_IMP(a_col_in_row, state_q == F_IDLE, (CW+1)'(col_q) < COLS_X)
  `TCCS_ASSERT_NXT(a_scroll_parks_cursor, push_o && push_cmd_o.scroll,
                   ({1'b0, cursor_q} == (CW+1)'(CELLS - COLUMNS)) && (col_q == '0))

endmodule

>>> src/tccs_back.sv
// Back of the console engine: clears the cell store after reset, carries out
// cell writes, reads and row scrolls, and holds the result. Depends on
// tccs_pkg and tccs_ram.
`include "text_console_cursor_scroll_assert.svh"

module tccs_back import tccs_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                queue_empty_i,
  input  cmd_t                head_cmd_i,
  output logic                pop_o,
  output logic                clear_busy_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [FIELD_AW-1:0] cursor_position_o,
  output logic [CELL_W-1:0]   cell_value_o,
  output logic                scrolled_o
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int CW    = $clog2(CELLS);
  localparam int CLW   = $clog2(COLUMNS);
  localparam logic [CW:0] CELLS_X = (CW+1)'(CELLS);
  localparam logic [CW:0] COLS_X  = (CW+1)'(COLUMNS);

  typedef enum logic [1:0] {
    B_CLEAR,
    B_RUN,
    B_READ,
    B_SCROLL
  } bstate_e;

  bstate_e             state_q;
  logic [CW-1:0]       clr_q;
  logic [CW-1:0]       base_q;    // physical index of the top row's first cell
  logic [CLW-1:0]      sweep_q;
  logic                out_valid_q;
  logic [FIELD_AW-1:0] out_cursor_q;
  logic [CELL_W-1:0]   out_value_q;
  logic                out_scrolled_q;

  logic [CW:0]         sum_x, base_nxt_x;
  logic [CW-1:0]       phys, sweep_addr;
  logic                ram_we;
  logic [CW-1:0]       ram_waddr;
  logic [CELL_W-1:0]   ram_wdata;
  logic [CELL_W-1:0]   ram_rdata;
  logic                out_set;

  // Rows rotate through the store: logical index plus top-row offset, wrapped.
  assign sum_x      = {1'b0, head_cmd_i.addr[CW-1:0]} + {1'b0, base_q};
  assign phys       = (sum_x >= CELLS_X) ? CW'(sum_x - CELLS_X) : sum_x[CW-1:0];
  assign sweep_addr = base_q + CW'(sweep_q);
  assign base_nxt_x = {1'b0, base_q} + COLS_X;

  assign pop_o        = (state_q == B_RUN) && !queue_empty_i && (!out_valid_q || out_ready_i);
  assign clear_busy_o = (state_q == B_CLEAR);
  assign out_set      = (pop_o && (head_cmd_i.kind != CMD_READ)) || (state_q == B_READ);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = phys;
    ram_wdata = head_cmd_i.data;
    case (state_q)
      B_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = BLANK_CELL;
      end
      B_RUN: begin
        ram_we = pop_o && (head_cmd_i.kind == CMD_WRITE);
      end
      B_SCROLL: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_addr;
        ram_wdata = BLANK_CELL;
      end
      default: begin
      end
    endcase
  end

  tccs_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELLS)
  ) u_cells (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(phys),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= B_CLEAR;
      clr_q          <= '0;
      base_q         <= '0;
      sweep_q        <= '0;
      out_valid_q    <= 1'b0;
      out_cursor_q   <= '0;
      out_value_q    <= '0;
      out_scrolled_q <= 1'b0;
    end else begin
      if (out_set) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        B_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == CW'(CELLS - 1)) begin
            state_q <= B_RUN;
          end
        end
        B_RUN: begin
          if (pop_o) begin
            out_cursor_q   <= head_cmd_i.cursor;
            out_scrolled_q <= head_cmd_i.scroll;
            if (head_cmd_i.kind == CMD_READ) begin
              state_q <= B_READ;
            end else begin
              out_value_q <= '0;
              if (head_cmd_i.scroll) begin
                sweep_q <= '0;
                state_q <= B_SCROLL;
              end
            end
          end
        end
        B_READ: begin
          out_value_q <= ram_rdata;
          state_q     <= B_RUN;
        end
        B_SCROLL: begin
          // Blank the old top row; it becomes the last row once the offset moves.
          sweep_q <= sweep_q + 1'b1;
          if (sweep_q == CLW'(COLUMNS - 1)) begin
            base_q  <= (base_nxt_x >= CELLS_X) ? '0 : base_nxt_x[CW-1:0];
            state_q <= B_RUN;
          end
        end
        default: begin
          state_q <= B_RUN;
        end
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign cursor_position_o = out_cursor_q;
  assign cell_value_o      = out_value_q;
  assign scrolled_o        = out_scrolled_q;

  `TCCS_ASSERT_IMP(a_pop_slot_free, pop_o, (state_q == B_RUN) && (!out_valid_q || out_ready_i))
  `TCCS_ASSERT_NXT(a_read_delivers, state_q == B_READ, out_valid_q && (state_q == B_RUN))
  `TCCS_ASSERT_IMP(a_base_on_screen, 1'b1, {1'b0, base_q} < CELLS_X)
  `TCCS_ASSERT_IMP(a_sweep_in_row, state_q == B_SCROLL, (CW+1)'(sweep_q) < COLS_X)

endmodule

>>> src/text_console_cursor_scroll.sv
// Top level of the text console engine: front, command queue and back.
// Depends on tccs_pkg, tccs_front, tccs_fifo and tccs_back.
//
//   channel  handshake                 payload
//   input    in_valid_i / in_ready_o   operation_i, char_code_i, new_cursor_i,
//                                      read_address_i
//   output   out_valid_o / out_ready_i cursor_position_o, cell_value_o, scrolled_o
//
// Puts, reads and unused codes enter one a beat; a set-cursor keeps the input
// closed while the F_DIV and F_COL states work out the column by a reciprocal multiply.
// The back answers a put or set straight from the pop and a read through the B_READ
// state (registered cell RAM); a scroll adds a B_SCROLL sweep that blanks one row.
// After reset the cell RAM is cleared one cell a cycle, with in_ready_o low. A
// stalled output fills the two-entry queue, after which the input stalls too.
module text_console_cursor_scroll import tccs_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          operation_i,
  input  logic [7:0]          char_code_i,
  input  logic [FIELD_AW-1:0] new_cursor_i,
  input  logic [FIELD_AW-1:0] read_address_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [FIELD_AW-1:0] cursor_position_o,
  output logic [CELL_W-1:0]   cell_value_o,
  output logic                scrolled_o
);

  logic push, pop, full, empty, clear_busy;
  cmd_t push_cmd, head_cmd;

  tccs_front #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .char_code_i   (char_code_i),
    .new_cursor_i  (new_cursor_i),
    .read_address_i(read_address_i),
    .clear_busy_i  (clear_busy),
    .queue_full_i  (full),
    .push_o        (push),
    .push_cmd_o    (push_cmd)
  );

  tccs_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_cmd_i(push_cmd),
    .full_o    (full),
    .pop_i     (pop),
    .pop_cmd_o (head_cmd),
    .empty_o   (empty)
  );

  tccs_back #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .queue_empty_i    (empty),
    .head_cmd_i       (head_cmd),
    .pop_o            (pop),
    .clear_busy_o     (clear_busy),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .cursor_position_o(cursor_position_o),
    .cell_value_o     (cell_value_o),
    .scrolled_o       (scrolled_o)
  );

endmodule
